// File: design/asc_pkg.sv
`default_nettype none

package asc_pkg;

   localparam int ENTRIES  = 16;
   localparam int KEY_BITS = 32;

   // fixed field widths
   localparam int LOOKUP_KEY_W = 32;
   localparam int SLOT_W       = 4;
   localparam int FRESH_W      = 15;
   localparam int SCORE_W      = 16;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int KEY_W = (KEY_BITS < LOOKUP_KEY_W) ? KEY_BITS : LOOKUP_KEY_W;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX   = 16'sh7fff;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN   = 16'sh8000;
   localparam logic        [FRESH_W-1:0] FRESH_RESET = 15'd100;

   // request codes
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef struct packed {
      logic                    req_type;
      logic [LOOKUP_KEY_W-1:0] lookup_key;
   } req_payload_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic              hit;
   } rsp_payload_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic tick;
      logic begin_scan;
      logic scan;
      logic commit_hit;
      logic commit_miss;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic last;
   } status_type;

endpackage

`default_nettype wire

// File: design/aging_score_slot_cache.sv
`default_nettype none

// Fully associative cache of ENTRIES slots (16 here) with use scores. A lookup
// transfer (start high while busy is low) ends after the last slot is compared,
// or earlier when the key hits: the key store is one RAM with a single read
// port, scanned one slot per cycle while the lowest score is tracked
// alongside. An aging tick lowers every score by one (saturating) and yields
// no result; start may be raised again in the very next cycle. Each result
// sits on rsp_data for exactly one cycle, marked by rsp_valid, and cannot be
// held off: the receiver must take it then. busy is low again in the cycle
// the result shows, so a new request can be taken alongside it. fresh_score
// resets to 100 and should be written only while the cache is idle. After
// reset all slots are invalid with score 0; no clearing pass is needed.
module aging_score_slot_cache (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire asc_pkg::req_payload_type       req_data,
   // result channel
   output logic                                rsp_valid,
   output asc_pkg::rsp_payload_type            rsp_data,
   // fresh_score register
   input  wire logic                           csr_we,
   input  wire logic [asc_pkg::FRESH_W-1:0]    csr_wdata
);

   asc_pkg::cmd_type    cmd;
   asc_pkg::status_type status;

   // Controller: idle / scan sequencing, decides hit or replacement.
   asc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_is_tick (req_data.req_type == asc_pkg::REQ_TICK),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   // Datapath: key RAM, valid bits, scores, minimum tracker and result register.
   asc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .lookup_key (req_data.lookup_key),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// File: design/asc_ram.sv
`default_nettype none

module asc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/asc_ctrl.sv
`default_nettype none

module asc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                req_is_tick,
   input  wire asc_pkg::status_type status,
   output asc_pkg::cmd_type         cmd,
   output logic                     busy
);

   asc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         asc_pkg::ST_IDLE: begin
            if (start && !req_is_tick) begin
               state_in = asc_pkg::ST_SCAN;
            end
         end
         asc_pkg::ST_SCAN: begin
            if (status.match || status.last) begin
               state_in = asc_pkg::ST_IDLE;
            end
         end
         default: state_in = asc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      case (state_ff)
         asc_pkg::ST_IDLE: begin
            cmd.tick       = start && req_is_tick;
            cmd.begin_scan = start && !req_is_tick;
         end
         asc_pkg::ST_SCAN: begin
            busy            = 1'b1;
            cmd.scan        = 1'b1;
            cmd.commit_hit  = status.match;
            cmd.commit_miss = !status.match && status.last;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: design/asc_datapath.sv
`default_nettype none

module asc_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire asc_pkg::cmd_type                      cmd,
   input  wire logic [asc_pkg::LOOKUP_KEY_W-1:0]      lookup_key,
   input  wire logic                                  csr_we,
   input  wire logic [asc_pkg::FRESH_W-1:0]           csr_wdata,
   output asc_pkg::status_type                        status,
   output logic                                       rsp_valid,
   output asc_pkg::rsp_payload_type                   rsp_data
);

   localparam int IDX_W = asc_pkg::IDX_W;
   localparam int CNT_W = asc_pkg::CNT_W;
   localparam int KEY_W = asc_pkg::KEY_W;

   logic [KEY_W-1:0]                   key_ff, key_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic                               cmp_live_ff, cmp_live_in;
   logic [IDX_W-1:0]                   cmp_idx_ff, cmp_idx_in;
   logic signed [asc_pkg::SCORE_W-1:0] min_score_ff, min_score_in;
   logic [IDX_W-1:0]                   min_idx_ff, min_idx_in;
   logic                               valid_ff [asc_pkg::ENTRIES];
   logic                               valid_in [asc_pkg::ENTRIES];
   logic signed [asc_pkg::SCORE_W-1:0] score_ff [asc_pkg::ENTRIES];
   logic signed [asc_pkg::SCORE_W-1:0] score_in [asc_pkg::ENTRIES];
   logic [asc_pkg::FRESH_W-1:0]        fresh_ff, fresh_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   asc_pkg::rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic                               issue;
   logic [IDX_W-1:0]                   rd_addr;
   logic [KEY_W-1:0]                   rd_key;
   logic signed [asc_pkg::SCORE_W-1:0] cur_score;
   logic                               take;
   logic [IDX_W-1:0]                   victim;

   assign issue   = cmd.scan && (cnt_ff < CNT_W'(asc_pkg::ENTRIES));
   assign rd_addr = cnt_ff[IDX_W-1:0];

   asc_ram #(
      .WIDTH (KEY_W),
      .DEPTH (asc_pkg::ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.commit_miss),
      .wr_addr (victim),
      .wr_data (key_ff),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_key)
   );

   // compare stage works on the slot read last cycle
   assign cur_score     = score_ff[cmp_idx_ff];
   assign take          = (cmp_idx_ff == '0) || (cur_score < min_score_ff);
   assign victim        = take ? cmp_idx_ff : min_idx_ff;
   assign status.match = cmp_live_ff && valid_ff[cmp_idx_ff] && (rd_key == key_ff);
   assign status.last  = cmp_live_ff && (cmp_idx_ff == IDX_W'(asc_pkg::ENTRIES - 1));

   always_comb begin
      key_in       = cmd.begin_scan ? lookup_key[KEY_W-1:0] : key_ff;
      cnt_in       = cmd.begin_scan ? '0 : (issue ? cnt_ff + 1'b1 : cnt_ff);
      cmp_live_in  = issue;
      cmp_idx_in   = issue ? rd_addr : cmp_idx_ff;
      min_score_in = min_score_ff;
      min_idx_in   = min_idx_ff;
      if (cmd.scan && cmp_live_ff) begin
         min_score_in = take ? cur_score : min_score_ff;
         min_idx_in   = victim;
      end
      fresh_in = csr_we ? csr_wdata : fresh_ff;

      for (int i = 0; i < asc_pkg::ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         score_in[i] = score_ff[i];
         if (cmd.tick && (score_ff[i] != asc_pkg::SCORE_MIN)) begin
            score_in[i] = score_ff[i] - 16'sd1;
         end
         if (cmd.commit_hit && (cmp_idx_ff == IDX_W'(i))
             && (score_ff[i] != asc_pkg::SCORE_MAX)) begin
            score_in[i] = score_ff[i] + 16'sd1;
         end
         if (cmd.commit_miss && (victim == IDX_W'(i))) begin
            valid_in[i] = 1'b1;
            score_in[i] = $signed({1'b0, fresh_ff});
         end
      end

      rsp_valid_in           = cmd.commit_hit || cmd.commit_miss;
      rsp_data_in.slot_index = asc_pkg::SLOT_W'(cmd.commit_hit ? cmp_idx_ff : victim);
      rsp_data_in.hit        = cmd.commit_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cmp_live_ff  <= 1'b0;
         fresh_ff     <= asc_pkg::FRESH_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < asc_pkg::ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            score_ff[i] <= '0;
         end
      end else begin
         cnt_ff       <= cnt_in;
         cmp_live_ff  <= cmp_live_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < asc_pkg::ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            score_ff[i] <= score_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      cmp_idx_ff   <= cmp_idx_in;
      min_score_ff <= min_score_in;
      min_idx_ff   <= min_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: design/asc_checker.sv
`default_nettype none

module asc_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire asc_pkg::req_payload_type req_data,
   input wire logic                     rsp_valid
);

   // the result strobe is never high in consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a tick never makes the cache busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.req_type == asc_pkg::REQ_TICK)) |=> !busy)
      else $error("tick left the cache busy");

   // a lookup transfer starts a scan
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.req_type == asc_pkg::REQ_LOOKUP)) |=> busy)
      else $error("lookup did not start a scan");

   // the result arrives as the scan ends
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result outside the end of a scan");

   assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("not idle after reset");

endmodule

bind aging_score_slot_cache asc_checker u_asc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
